>>> rtl/chca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Package for the compacting handle allocator
// Field widths, request and status codes, sequencer states and the operation
// codes of the shared arithmetic unit.
// ----------------------------------------------------------------------------
package chca_pkg;

  // Field widths of the request and response transactions.
  localparam int IDX_W    = 7;
  localparam int SIZE_W   = 18;
  localparam int STATUS_W = 3;
  localparam int OFF_W    = 17;

  // Request type codes.
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Response status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_RANGE = 3'd1,
    ST_SIZE  = 3'd2,
    ST_BUSY  = 3'd3,
    ST_FREE  = 3'd4
  } status_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_REM,
    S_ACHK,
    S_AUPD,
    S_DLOOK,
    S_DEND,
    S_DCNT,
    S_DUSED,
    S_DREM,
    S_WALK,
    S_EMIT
  } state_e;

  // Operations of the shared add/subtract unit.
  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

endpackage

>>> rtl/chca_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request and response channels of the compacting handle allocator
// Valid/ready channels; a transaction moves when valid and ready are high.
// ----------------------------------------------------------------------------

// Request channel: allocate or free one handle.
interface chca_req_if import chca_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [IDX_W-1:0]  handle_index;
  logic [SIZE_W-1:0] alloc_size;

  modport source (output valid, output req_type, output handle_index,
                  output alloc_size, input ready);
  modport sink   (input valid, input req_type, input handle_index,
                  input alloc_size, output ready);
endinterface

// Response channel: status, block offset, move descriptor and free bytes.
interface chca_rsp_if import chca_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [OFF_W-1:0]    block_offset;
  logic [SIZE_W-1:0]   move_source;
  logic [OFF_W-1:0]    move_dest;
  logic [SIZE_W-1:0]   move_count;
  logic [SIZE_W-1:0]   bytes_remaining;

  modport source (output valid, output status, output block_offset,
                  output move_source, output move_dest, output move_count,
                  output bytes_remaining, input ready);
  modport sink   (input valid, input status, input block_offset,
                  input move_source, input move_dest, input move_count,
                  input bytes_remaining, output ready);
endinterface

>>> rtl/compacting_handle_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Compacting handle allocator
// Keeps a table of NUM_HANDLES handles (valid, offset, size) for blocks packed
// from offset 0 in a region of REGION_BYTES bytes. An allocate places the
// block at the top of the used region; a free closes the gap by moving every
// live block above it down and reports a move descriptor for a copy engine.
// One request is in work at a time. A successful free walks the handle RAM,
// which reads one entry per cycle and rewrites each entry that moves through
// its single read and single write port. The response sits in an output
// register, so a new request is taken while the last response waits.
// ----------------------------------------------------------------------------
module compacting_handle_allocator_unit import chca_pkg::*; #(
  parameter int NUM_HANDLES  = 128,
  parameter int REGION_BYTES = 131072
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  chca_req_if.sink   req_i,
  chca_rsp_if.source rsp_o
);

  localparam int CW = $clog2(REGION_BYTES + 1);
  localparam int UW = (CW > SIZE_W) ? CW : SIZE_W;
  localparam int AW = UW + 1;
  localparam int EW = 2 * UW;
  localparam int IW = (NUM_HANDLES > 1) ? $clog2(NUM_HANDLES) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_HANDLES - 1);
  localparam logic [UW-1:0] REGION   = UW'(REGION_BYTES);

  // Sequencer and request registers.
  state_e                 state_q, state_d;
  logic                   req_q;
  logic [IW-1:0]          idx_q;
  logic [UW-1:0]          size_q;
  status_e                status_q;

  // Allocator state.
  logic [NUM_HANDLES-1:0] valid_q;
  logic [UW-1:0]          used_q;
  logic [UW-1:0]          rem_q;

  // Working registers of a free.
  logic [UW-1:0]          start_q;
  logic [UW-1:0]          sz_q;
  logic [AW-1:0]          end_q;
  logic [UW-1:0]          cnt_q;
  logic [IW-1:0]          walk_q;
  logic [UW-1:0]          res_off_q;

  // Response register.
  logic                   rsp_valid_q;
  status_e                out_status_q;
  logic [UW-1:0]          out_off_q;
  logic [AW-1:0]          out_src_q;
  logic [UW-1:0]          out_dst_q;
  logic [UW-1:0]          out_cnt_q;
  logic [UW-1:0]          out_rem_q;

  // Shared unit and RAM control.
  alu_op_e                alu_op;
  logic [AW-1:0]          alu_a, alu_b, cmp_a, cmp_b;
  logic [AW:0]            alu_res;
  logic                   alu_gt;
  logic                   borrow;
  logic [UW-1:0]          diff;
  logic [UW-1:0]          diff_sat;
  logic                   ram_we;
  logic [IW-1:0]          ram_waddr, ram_raddr;
  logic [EW-1:0]          ram_wdata, ram_rdata;
  logic [UW-1:0]          rd_off, rd_size;

  // Request decode.
  logic                   req_acc;
  logic                   req_oor;
  logic [31:0]            idx_ext;
  logic                   size_zero;
  logic                   walk_hit;
  logic                   rsp_load;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign idx_ext     = 32'(req_i.handle_index);
  assign req_oor     = (idx_ext >= 32'(NUM_HANDLES));
  assign size_zero   = (size_q == '0);
  assign rsp_load    = (state_q == S_EMIT) && (!rsp_valid_q || rsp_o.ready);

  assign rd_off   = ram_rdata[UW-1:0];
  assign rd_size  = ram_rdata[EW-1:UW];
  assign borrow   = alu_res[AW];
  assign diff     = alu_res[UW-1:0];
  assign diff_sat = borrow ? '0 : diff;
  assign walk_hit = valid_q[walk_q] && (walk_q != idx_q) && alu_gt;

  // Handle table: offset in the low half, size in the high half.
  chca_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_HANDLES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  chca_alu #(
    .W (AW)
  ) u_alu (
    .op_i    (alu_op),
    .a_i     (alu_a),
    .b_i     (alu_b),
    .cmp_a_i (cmp_a),
    .cmp_b_i (cmp_b),
    .res_o   (alu_res),
    .gt_o    (alu_gt)
  );

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_acc) state_d = S_REM;
      end
      S_REM: begin
        if (status_q == ST_RANGE) state_d = S_EMIT;
        else if (req_q == REQ_ALLOC) state_d = S_ACHK;
        else state_d = S_DLOOK;
      end
      S_ACHK: begin
        if (size_zero || borrow || valid_q[idx_q]) state_d = S_EMIT;
        else state_d = S_AUPD;
      end
      S_AUPD:  state_d = S_EMIT;
      S_DLOOK: begin
        if (!valid_q[idx_q]) state_d = S_EMIT;
        else state_d = S_DEND;
      end
      S_DEND:  state_d = S_DCNT;
      S_DCNT:  state_d = S_DUSED;
      S_DUSED: state_d = S_DREM;
      S_DREM:  state_d = S_WALK;
      S_WALK: begin
        if (walk_q == LAST_IDX) state_d = S_EMIT;
      end
      S_EMIT: begin
        if (rsp_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Operands of the shared unit and RAM control for each step.
  always_comb begin
    alu_op    = ALU_SUB;
    alu_a     = '0;
    alu_b     = '0;
    cmp_a     = '0;
    cmp_b     = '0;
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = {size_q, used_q};
    ram_raddr = idx_q;
    case (state_q)
      S_REM, S_DREM: begin
        alu_a = AW'(REGION);
        alu_b = AW'(used_q);
        if (state_q == S_DREM) ram_raddr = '0;
      end
      S_ACHK: begin
        alu_a  = AW'(rem_q);
        alu_b  = AW'(size_q);
        ram_we = !size_zero && !borrow && !valid_q[idx_q];
      end
      S_AUPD: begin
        alu_op = ALU_ADD;
        alu_a  = AW'(used_q);
        alu_b  = AW'(size_q);
      end
      S_DEND: begin
        alu_op = ALU_ADD;
        alu_a  = AW'(rd_off);
        alu_b  = AW'(rd_size);
      end
      S_DCNT: begin
        alu_a = AW'(used_q);
        alu_b = end_q;
      end
      S_DUSED: begin
        alu_a = AW'(used_q);
        alu_b = AW'(sz_q);
      end
      S_WALK: begin
        alu_a     = AW'(rd_off);
        alu_b     = AW'(sz_q);
        cmp_a     = AW'(rd_off);
        cmp_b     = AW'(start_q);
        ram_we    = walk_hit;
        ram_waddr = walk_q;
        ram_wdata = {rd_size, diff_sat};
        ram_raddr = walk_q + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Allocator state: valid marks and the used byte count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      used_q  <= '0;
    end else begin
      case (state_q)
        S_ACHK: begin
          if (ram_we) valid_q[idx_q] <= 1'b1;
        end
        S_AUPD:  used_q <= alu_res[UW-1:0];
        S_DUSED: used_q <= diff_sat;
        S_WALK: begin
          if (walk_q == LAST_IDX) valid_q[idx_q] <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Request capture and per-step working registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (req_acc) begin
          req_q     <= req_i.req_type;
          idx_q     <= idx_ext[IW-1:0];
          size_q    <= UW'(req_i.alloc_size);
          status_q  <= req_oor ? ST_RANGE : ST_OK;
          res_off_q <= '0;
          start_q   <= '0;
          end_q     <= '0;
          cnt_q     <= '0;
        end
      end
      S_REM, S_DREM: begin
        rem_q  <= diff_sat;
        walk_q <= '0;
      end
      S_ACHK: begin
        if (size_zero || borrow) begin
          status_q <= ST_SIZE;
        end else if (valid_q[idx_q]) begin
          status_q <= ST_BUSY;
        end else begin
          res_off_q <= used_q;
          rem_q     <= diff;
        end
      end
      S_DLOOK: begin
        if (!valid_q[idx_q]) status_q <= ST_FREE;
      end
      S_DEND: begin
        start_q   <= rd_off;
        sz_q      <= rd_size;
        res_off_q <= rd_off;
        end_q     <= alu_res[AW-1:0];
      end
      S_DCNT: cnt_q <= diff_sat;
      S_WALK: walk_q <= walk_q + 1'b1;
      default: begin
      end
    endcase
  end

  // Response register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      out_status_q <= status_q;
      out_off_q    <= res_off_q;
      out_src_q    <= end_q;
      out_dst_q    <= start_q;
      out_cnt_q    <= cnt_q;
      out_rem_q    <= rem_q;
    end
  end

  assign rsp_o.valid           = rsp_valid_q;
  assign rsp_o.status          = out_status_q;
  assign rsp_o.block_offset    = out_off_q[OFF_W-1:0];
  assign rsp_o.move_source     = out_src_q[SIZE_W-1:0];
  assign rsp_o.move_dest       = out_dst_q[OFF_W-1:0];
  assign rsp_o.move_count      = out_cnt_q[SIZE_W-1:0];
  assign rsp_o.bytes_remaining = out_rem_q[SIZE_W-1:0];

  // The compaction walk never rewrites the entry being freed.
  a_walk_skips_freed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK && ram_we) |-> (ram_waddr != idx_q))
    else $error("compaction walk wrote the freed handle");

  // The used byte count never runs past the region.
  a_used_in_region: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q <= REGION))
    else $error("used byte count exceeds the region");

  // Free and used bytes add up to the region when a successful response is formed.
  a_rem_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && status_q == ST_OK) |->
      ((AW'(rem_q) + AW'(used_q)) == AW'(REGION)))
    else $error("free and used byte counts disagree");

  // The walk visits the table one entry per cycle without gaps.
  a_walk_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK && walk_q != LAST_IDX) |=>
      (state_q == S_WALK && walk_q == $past(walk_q) + 1'b1))
    else $error("compaction walk skipped or stalled");

  // A successful allocate leaves its handle marked live.
  a_alloc_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_AUPD) |-> valid_q[idx_q])
    else $error("allocated handle is not marked live");

endmodule

>>> rtl/chca_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module chca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/chca_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared arithmetic unit of the allocator
// One add/subtract with carry-out and one magnitude compare, time-shared by
// the sequencer for every size check, offset shift and byte count.
// ----------------------------------------------------------------------------
module chca_alu import chca_pkg::*; #(
  parameter int W = 19
) (
  input  alu_op_e      op_i,
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic [W-1:0] cmp_a_i,
  input  logic [W-1:0] cmp_b_i,
  output logic [W:0]   res_o,
  output logic         gt_o
);

  // Add or subtract; the top bit is the carry, or the borrow when a < b.
  always_comb begin
    case (op_i)
      ALU_ADD: res_o = {1'b0, a_i} + {1'b0, b_i};
      ALU_SUB: res_o = {1'b0, a_i} - {1'b0, b_i};
      default: res_o = '0;
    endcase
  end

  // Unsigned greater-than compare.
  assign gt_o = (cmp_a_i > cmp_b_i);

endmodule

>>> tb/sv/compacting_handle_allocator_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the compacting handle allocator
// Drives allocate and free requests into the block, first a directed list of
// corner cases and then a stream of mostly well-formed random requests. A
// handle table model in a scoreboard class predicts each response, which is
// compared field by field. Both channels idle at random, and the response
// side holds off once for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module compacting_handle_allocator_unit_test;
  import chca_pkg::*;

  localparam int NUM_HANDLES  = 128;
  localparam int REGION_BYTES = 131072;
  localparam int RANDOM_REQS  = 550;
  localparam int STUCK_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 800;
  localparam int DRAIN_CYCLES = 300;

  typedef struct packed {
    logic              req_type;
    logic [IDX_W-1:0]  handle_index;
    logic [SIZE_W-1:0] alloc_size;
  } alloc_req_t;

  typedef struct packed {
    status_e           status;
    logic [OFF_W-1:0]  block_offset;
    logic [SIZE_W-1:0] move_source;
    logic [OFF_W-1:0]  move_dest;
    logic [SIZE_W-1:0] move_count;
    logic [SIZE_W-1:0] bytes_remaining;
  } alloc_rsp_t;

  // Handle table model: predicts one response per accepted request and
  // keeps the predictions in order until the block returns them.
  class handle_table_model;
    bit          live [NUM_HANDLES];
    int unsigned base [NUM_HANDLES];
    int unsigned span [NUM_HANDLES];
    int unsigned used;
    alloc_rsp_t  expected_rsp [$];
    int unsigned mismatches;

    function new();
      used       = 0;
      mismatches = 0;
    endfunction

    function int unsigned remaining();
      return (used >= REGION_BYTES) ? 0 : REGION_BYTES - used;
    endfunction

    function void note_request(alloc_req_t r);
      alloc_rsp_t  e;
      int unsigned idx;
      int unsigned start;
      int unsigned sz;
      int unsigned stop;
      int unsigned cnt;
      idx = r.handle_index;
      e   = '0;
      e.status = ST_OK;
      if (idx >= NUM_HANDLES) begin
        e.status = ST_RANGE;
      end else if (r.req_type == REQ_ALLOC) begin
        if (r.alloc_size == 0 || r.alloc_size > remaining()) begin
          e.status = ST_SIZE;
        end else if (live[idx]) begin
          e.status = ST_BUSY;
        end else begin
          live[idx]      = 1'b1;
          base[idx]      = used;
          span[idx]      = r.alloc_size;
          e.block_offset = OFF_W'(used);
          used           = used + r.alloc_size;
        end
      end else begin
        if (!live[idx]) begin
          e.status = ST_FREE;
        end else begin
          start = base[idx];
          sz    = span[idx];
          stop  = start + sz;
          cnt   = (used > stop) ? used - stop : 0;
          // Every live block above the freed one slides down by its size.
          for (int i = 0; i < NUM_HANDLES; i++) begin
            if (i != idx && live[i] && base[i] > start) begin
              base[i] = (base[i] >= sz) ? base[i] - sz : 0;
            end
          end
          live[idx]      = 1'b0;
          span[idx]      = 0;
          used           = (used >= sz) ? used - sz : 0;
          e.block_offset = OFF_W'(start);
          e.move_source  = SIZE_W'(stop);
          e.move_dest    = OFF_W'(start);
          e.move_count   = SIZE_W'(cnt);
        end
      end
      e.bytes_remaining = SIZE_W'(remaining());
      expected_rsp.push_back(e);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_response(alloc_rsp_t act);
      alloc_rsp_t e;
      if (expected_rsp.size() == 0) begin
        $error("response transaction with no request pending");
        mismatches++;
        return;
      end
      e = expected_rsp.pop_front();
      compare_field("status", e.status, act.status);
      compare_field("block_offset", e.block_offset, act.block_offset);
      compare_field("move_source", e.move_source, act.move_source);
      compare_field("move_dest", e.move_dest, act.move_dest);
      compare_field("move_count", e.move_count, act.move_count);
      compare_field("bytes_remaining", e.bytes_remaining, act.bytes_remaining);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic hold_off = 1'b0;
  bit   req_offering;
  int   burst_left;
  int   requests_accepted;
  int   stuck_cycles;
  int   rx_mode;
  int   rx_left;

  handle_table_model table_model;

  chca_req_if req_bus ();
  chca_rsp_if rsp_bus ();

  compacting_handle_allocator_unit #(
    .NUM_HANDLES  (NUM_HANDLES),
    .REGION_BYTES (REGION_BYTES)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  always #5 clk_i = ~clk_i;

  // Offers one request and waits for the edge where it is accepted. Between
  // bursts the valid line may drop for a random gap before the task returns.
  task automatic send_request(input logic kind, input int unsigned idx,
                              input int unsigned size);
    alloc_req_t r;
    int         gap;
    r.req_type     = kind;
    r.handle_index = IDX_W'(idx);
    r.alloc_size   = SIZE_W'(size);
    req_bus.valid        <= 1'b1;
    req_bus.req_type     <= r.req_type;
    req_bus.handle_index <= r.handle_index;
    req_bus.alloc_size   <= r.alloc_size;
    req_offering = 1'b1;
    do @(posedge clk_i); while (req_bus.ready !== 1'b1);
    table_model.note_request(r);
    requests_accepted++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(3) == 0) ? $urandom_range(20, 150) : $urandom_range(0, 4);
      if (gap > 0) begin
        req_bus.valid <= 1'b0;
        req_offering = 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Builds a random request from the current table: mostly allocates into
  // free handles and frees of live ones, with some failing cases and noise.
  function automatic alloc_req_t pick_request();
    alloc_req_t  r;
    int          live_idx [$];
    int          free_idx [$];
    int          roll;
    int          size_roll;
    int unsigned room;
    bit          want_alloc;
    foreach (table_model.live[i]) begin
      if (table_model.live[i]) live_idx.push_back(i);
      else free_idx.push_back(i);
    end
    room           = table_model.remaining();
    r.req_type     = 1'($urandom_range(1));
    r.handle_index = IDX_W'($urandom_range(NUM_HANDLES - 1));
    r.alloc_size   = SIZE_W'($urandom_range(0, (1 << SIZE_W) - 1));
    roll           = $urandom_range(99);
    if (roll < 6) return r;
    want_alloc = (live_idx.size() == 0) ||
                 (live_idx.size() < NUM_HANDLES && room > 0 &&
                  $urandom_range(99) < ((table_model.used < REGION_BYTES / 2) ? 65 : 35));
    if (want_alloc) begin
      r.req_type = REQ_ALLOC;
      if (roll < 10 && live_idx.size() > 0) begin
        r.handle_index = IDX_W'(live_idx[$urandom_range(live_idx.size() - 1)]);
      end else if (free_idx.size() > 0) begin
        r.handle_index = IDX_W'(free_idx[$urandom_range(free_idx.size() - 1)]);
      end
      size_roll = $urandom_range(99);
      if (size_roll < 3) r.alloc_size = '0;
      else if (size_roll < 6) r.alloc_size = SIZE_W'(room + 1);
      else if (size_roll < 10 && room > 0) r.alloc_size = SIZE_W'(room);
      else if (size_roll < 25) r.alloc_size = SIZE_W'($urandom_range(1, 32768));
      else r.alloc_size = SIZE_W'($urandom_range(1, 2048));
    end else begin
      r.req_type = REQ_FREE;
      if (roll < 12 && free_idx.size() > 0) begin
        r.handle_index = IDX_W'(free_idx[$urandom_range(free_idx.size() - 1)]);
      end else begin
        r.handle_index = IDX_W'(live_idx[$urandom_range(live_idx.size() - 1)]);
      end
    end
    return r;
  endfunction

  // Response side: checks each transaction and stalls on a changing pattern.
  always @(posedge clk_i) begin
    alloc_rsp_t act;
    bit         go;
    if (rst_ni === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      act.status          = status_e'(rsp_bus.status);
      act.block_offset    = rsp_bus.block_offset;
      act.move_source     = rsp_bus.move_source;
      act.move_dest       = rsp_bus.move_dest;
      act.move_count      = rsp_bus.move_count;
      act.bytes_remaining = rsp_bus.bytes_remaining;
      table_model.check_response(act);
    end
    if (rx_left <= 0) begin
      rx_mode = $urandom_range(3);
      rx_left = $urandom_range(5, 80);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      0:       go = 1'b1;
      1:       go = 1'($urandom_range(1));
      2:       go = ($urandom_range(7) == 0);
      default: go = ((rx_left % 16) == 0);
    endcase
    rsp_bus.ready <= go && !hold_off;
  end

  // One long hold-off on the response side while requests keep coming.
  initial begin
    while (requests_accepted < 150) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // Watchdog on cycles where neither channel moves a transaction.
  always @(posedge clk_i) begin
    if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
        (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    alloc_req_t r;
    table_model          = new();
    rst_ni               = 1'b0;
    req_bus.valid        = 1'b0;
    req_bus.req_type     = REQ_ALLOC;
    req_bus.handle_index = '0;
    req_bus.alloc_size   = '0;
    rsp_bus.ready        = 1'b0;
    req_offering         = 1'b0;
    burst_left           = 4;
    requests_accepted    = 0;
    stuck_cycles         = 0;
    rx_mode              = 0;
    rx_left              = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: failing checks, a full region, moves from the bottom,
    // the middle and the top, and every bit of each request field at both values.
    send_request(REQ_FREE,  0,   18'h3FFFF);
    send_request(REQ_ALLOC, 0,   0);
    send_request(REQ_ALLOC, 127, 18'h3FFFF);
    send_request(REQ_ALLOC, 127, REGION_BYTES + 1);
    send_request(REQ_ALLOC, 127, REGION_BYTES);
    send_request(REQ_ALLOC, 1,   1);
    send_request(REQ_FREE,  127, 0);
    send_request(REQ_ALLOC, 0,   100);
    send_request(REQ_ALLOC, 0,   50);
    send_request(REQ_ALLOC, 1,   200);
    send_request(REQ_ALLOC, 2,   300);
    send_request(REQ_ALLOC, 127, 1);
    send_request(REQ_FREE,  1,   18'h2AAAA);
    send_request(REQ_FREE,  127, 0);
    send_request(REQ_FREE,  1,   0);
    send_request(REQ_FREE,  0,   0);
    send_request(REQ_FREE,  2,   0);
    send_request(REQ_ALLOC, 64,  REGION_BYTES - 1);
    send_request(REQ_ALLOC, 63,  1);
    send_request(REQ_ALLOC, 62,  1);
    send_request(REQ_FREE,  64,  0);
    send_request(REQ_FREE,  63,  18'h15555);

    // Random part.
    for (int n = 0; n < RANDOM_REQS; n++) begin
      r = pick_request();
      send_request(r.req_type, r.handle_index, r.alloc_size);
    end
    if (req_offering) req_bus.valid <= 1'b0;

    // Drain: all responses back, then a quiet stretch for stray ones.
    while (table_model.expected_rsp.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (table_model.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
